[rtl/core/nace_pkg.sv]
// ----------------------------------------------------------------------------
// nace_pkg
// Shared types and constants for the normal-angle curvature estimator.
// ----------------------------------------------------------------------------
package nace_pkg;

    localparam int MaxNeighbors = 21;
    localparam int CntW         = 5;
    localparam int SumW         = 40;
    localparam int ProdSteps    = 9;
    localparam int SqSteps      = 3;
    localparam int SqrtSteps    = 30;
    localparam int CordicSteps  = 15;
    localparam int DivSteps     = 40;
    localparam int FqDepth      = 4;
    localparam int FqPtrW       = 2;

    localparam logic [15:0] AngPi     = 16'd51472;
    localparam logic [15:0] AngHalfPi = 16'd25736;
    localparam logic [9:0]  BinMax    = 10'd1023;

    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               use_nb;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [9:0] bin;
        logic       none;
    } result_t;

    typedef struct packed {
        logic [CntW-1:0] valid_count;
        logic            busy;
    } back_status_t;

    // atan(2^-i) in Q2.14
    function automatic logic [13:0] atan_entry(input logic [3:0] i);
        logic [13:0] v;
        case (i)
            4'd0:    v = 14'd12868;
            4'd1:    v = 14'd7596;
            4'd2:    v = 14'd4014;
            4'd3:    v = 14'd2037;
            4'd4:    v = 14'd1023;
            4'd5:    v = 14'd512;
            4'd6:    v = 14'd256;
            4'd7:    v = 14'd128;
            4'd8:    v = 14'd64;
            4'd9:    v = 14'd32;
            4'd10:   v = 14'd16;
            4'd11:   v = 14'd8;
            4'd12:   v = 14'd4;
            4'd13:   v = 14'd2;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/nace_front.sv]
// ----------------------------------------------------------------------------
// nace_front
// Input side: accepts words and holds them in a short queue.
// ----------------------------------------------------------------------------
module nace_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  nace_pkg::item_t in_item,
    input  logic          deq,
    output logic          q_valid,
    output nace_pkg::item_t q_item
);
    import nace_pkg::*;

    item_t            mem_reg [FqDepth];
    logic [FqPtrW-1:0] wr_ptr_reg;
    logic [FqPtrW-1:0] rd_ptr_reg;
    logic [FqPtrW:0]   cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == (FqPtrW+1)'(FqDepth));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = deq && q_valid;

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (!do_push && do_pop) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

[rtl/core/nace_result.sv]
// ----------------------------------------------------------------------------
// nace_result
// Two-entry result queue toward the output side.
// ----------------------------------------------------------------------------
module nace_result (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  nace_pkg::result_t wr_data,
    output logic              res_full,
    input  logic              pop,
    output logic              empty,
    output nace_pkg::result_t rd_data
);
    import nace_pkg::*;

    result_t    ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign rd_data  = ent_reg[rd_ptr_reg];
    assign do_wr    = wr && !res_full;
    assign do_rd    = pop && !empty;

    always_ff @(posedge clk) begin
        if (do_wr) begin
            ent_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else begin
            if (do_wr) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_rd) rd_ptr_reg <= ~rd_ptr_reg;
            if (do_wr && !do_rd)      cnt_reg <= cnt_reg + 2'd1;
            else if (!do_wr && do_rd) cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

[rtl/core/nace_back.sv]
// ----------------------------------------------------------------------------
// nace_back
// Execution engine: cross/dot products, integer sqrt, CORDIC atan2,
// scaled accumulation and the final mean by restoring division.
// ----------------------------------------------------------------------------
module nace_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [15:0]            scale,
    input  logic                   q_valid,
    input  nace_pkg::item_t        q_item,
    output logic                   deq,
    input  logic                   res_full,
    output logic                   res_wr,
    output nace_pkg::result_t      res_data,
    output nace_pkg::back_status_t status
);
    import nace_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PROD, S_SQ, S_SQRT, S_CORD, S_ACC, S_FIN, S_DIV
    } state_t;

    state_t               state_reg;
    logic                 emit_reg;
    item_t                it_reg;
    logic [5:0]           step_reg;
    logic signed [32:0]   cx_reg, cy_reg, cz_reg, d_reg;
    logic [59:0]          sq_reg;
    logic [31:0]          rem_reg;
    logic [29:0]          root_reg;
    logic signed [33:0]   x_reg, y_reg;
    logic signed [17:0]   z_reg;
    logic [15:0]          angle_reg;
    logic [SumW-1:0]      sum_reg;
    logic [CntW-1:0]      cnt_reg;
    logic [SumW-1:0]      q_reg;
    logic [5:0]           drem_reg;
    result_t              res_reg;

    // product step operands
    logic signed [15:0] op_a, op_b;
    logic signed [31:0] prod;
    logic signed [32:0] prod_x;
    logic [1:0]         acc_sel;
    logic               acc_sub;

    always_comb begin
        op_a    = it_reg.qy;
        op_b    = it_reg.nz;
        acc_sel = 2'd0;
        acc_sub = 1'b0;
        case (step_reg[3:0])
            4'd0: begin op_a = it_reg.qy; op_b = it_reg.nz; acc_sel = 2'd0; end
            4'd1: begin op_a = it_reg.qz; op_b = it_reg.ny; acc_sel = 2'd0; acc_sub = 1'b1; end
            4'd2: begin op_a = it_reg.qz; op_b = it_reg.nx; acc_sel = 2'd1; end
            4'd3: begin op_a = it_reg.qx; op_b = it_reg.nz; acc_sel = 2'd1; acc_sub = 1'b1; end
            4'd4: begin op_a = it_reg.qx; op_b = it_reg.ny; acc_sel = 2'd2; end
            4'd5: begin op_a = it_reg.qy; op_b = it_reg.nx; acc_sel = 2'd2; acc_sub = 1'b1; end
            4'd6: begin op_a = it_reg.qx; op_b = it_reg.nx; acc_sel = 2'd3; end
            4'd7: begin op_a = it_reg.qy; op_b = it_reg.ny; acc_sel = 2'd3; end
            4'd8: begin op_a = it_reg.qz; op_b = it_reg.nz; acc_sel = 2'd3; end
            default: ;
        endcase
    end

    assign prod   = op_a * op_b;
    assign prod_x = acc_sub ? -33'(prod) : 33'(prod);

    // squares of the Q.28 cross components
    logic signed [30:0] csh;
    logic signed [61:0] sqp;
    logic signed [30:0] dsh;

    always_comb begin
        case (step_reg[1:0])
            2'd0:    csh = 31'(cx_reg >>> 2);
            2'd1:    csh = 31'(cy_reg >>> 2);
            default: csh = 31'(cz_reg >>> 2);
        endcase
    end

    assign sqp = csh * csh;
    assign dsh = 31'(d_reg >>> 2);

    // sqrt digit step
    logic [31:0] rem_w;
    logic [31:0] trial;
    logic        sq_ge;

    assign rem_w = {rem_reg[29:0], sq_reg[59:58]};
    assign trial = {root_reg, 2'b01};
    assign sq_ge = (rem_w >= trial);

    // CORDIC step
    logic signed [33:0] xs, ys;
    logic signed [17:0] atan_v;
    logic signed [17:0] z_fin;

    assign xs     = x_reg >>> step_reg[3:0];
    assign ys     = y_reg >>> step_reg[3:0];
    assign atan_v = 18'(atan_entry(step_reg[3:0]));
    assign z_fin  = (y_reg >= 0) ? z_reg + atan_v : z_reg - atan_v;

    // division step
    logic [5:0]  drem_w;
    logic        dv_ge;
    logic [17:0] mean;

    assign drem_w = {drem_reg[4:0], q_reg[SumW-1]};
    assign dv_ge  = (drem_w >= {1'b0, cnt_reg});
    assign mean   = q_reg[SumW-1:22];

    logic [31:0] scaled;
    assign scaled = angle_reg * scale;

    logic take_use;
    assign take_use = q_item.use_nb && (cnt_reg < CntW'(MaxNeighbors));

    assign deq      = (state_reg == S_IDLE) && !emit_reg && q_valid;
    assign res_wr   = emit_reg;
    assign res_data = res_reg;
    assign status   = '{valid_count: cnt_reg, busy: (state_reg != S_IDLE) || emit_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            emit_reg  <= 1'b0;
            it_reg    <= '0;
            step_reg  <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
            d_reg     <= '0;
            sq_reg    <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            angle_reg <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            q_reg     <= '0;
            drem_reg  <= '0;
            res_reg   <= '0;
        end
        else begin
            if (emit_reg) begin
                // result waits here until the queue has room
                if (!res_full) begin
                    emit_reg <= 1'b0;
                    sum_reg  <= '0;
                    cnt_reg  <= '0;
                end
            end
            else begin
                case (state_reg)
                    S_IDLE: begin
                        if (q_valid) begin
                            it_reg   <= q_item;
                            step_reg <= '0;
                            cx_reg   <= '0;
                            cy_reg   <= '0;
                            cz_reg   <= '0;
                            d_reg    <= '0;
                            sq_reg   <= '0;
                            if (take_use)         state_reg <= S_PROD;
                            else if (q_item.last) state_reg <= S_FIN;
                        end
                    end
                    S_PROD: begin
                        case (acc_sel)
                            2'd0:    cx_reg <= cx_reg + prod_x;
                            2'd1:    cy_reg <= cy_reg + prod_x;
                            2'd2:    cz_reg <= cz_reg + prod_x;
                            default: d_reg  <= d_reg + prod_x;
                        endcase
                        if (step_reg == 6'(ProdSteps-1)) begin
                            step_reg  <= '0;
                            state_reg <= S_SQ;
                        end
                        else step_reg <= step_reg + 6'd1;
                    end
                    S_SQ: begin
                        sq_reg <= sq_reg + sqp[59:0];
                        if (step_reg == 6'(SqSteps-1)) begin
                            step_reg  <= '0;
                            rem_reg   <= '0;
                            root_reg  <= '0;
                            state_reg <= S_SQRT;
                        end
                        else step_reg <= step_reg + 6'd1;
                    end
                    S_SQRT: begin
                        sq_reg <= {sq_reg[57:0], 2'b00};
                        if (sq_ge) begin
                            rem_reg  <= rem_w - trial;
                            root_reg <= {root_reg[28:0], 1'b1};
                        end
                        else begin
                            rem_reg  <= rem_w;
                            root_reg <= {root_reg[28:0], 1'b0};
                        end
                        if (step_reg == 6'(SqrtSteps-1)) begin
                            step_reg  <= '0;
                            state_reg <= S_CORD;
                        end
                        else step_reg <= step_reg + 6'd1;
                        // all root bits are in place when S_CORD starts
                    end
                    S_CORD: begin
                        if (step_reg == 6'd0 && z_reg == '0 && x_reg == '0
                                && y_reg == '0) begin
                            // first CORDIC cycle: load from root and dot
                            if (root_reg == '0) begin
                                angle_reg <= (dsh < 0) ? AngPi : 16'd0;
                                state_reg <= S_ACC;
                            end
                            else if (dsh < 0) begin
                                x_reg <= 34'({4'b0, root_reg});
                                y_reg <= -34'(dsh);
                                z_reg <= 18'(AngHalfPi);
                                step_reg <= 6'd32;
                            end
                            else begin
                                x_reg <= 34'(dsh);
                                y_reg <= 34'({4'b0, root_reg});
                                z_reg <= '0;
                                step_reg <= 6'd32;
                            end
                        end
                        else begin
                            if (step_reg[5]) step_reg <= '0;
                            else begin
                                if (y_reg >= 0) begin
                                    x_reg <= x_reg + ys;
                                    y_reg <= y_reg - xs;
                                end
                                else begin
                                    x_reg <= x_reg - ys;
                                    y_reg <= y_reg + xs;
                                end
                                z_reg <= z_fin;
                                if (step_reg == 6'(CordicSteps-1)) begin
                                    if (z_fin < 0) angle_reg <= 16'd0;
                                    else if (z_fin > $signed({2'b0, AngPi}))
                                        angle_reg <= AngPi;
                                    else angle_reg <= z_fin[15:0];
                                    state_reg <= S_ACC;
                                end
                                else step_reg <= step_reg + 6'd1;
                            end
                        end
                    end
                    S_ACC: begin
                        sum_reg <= sum_reg + SumW'(scaled);
                        cnt_reg <= cnt_reg + 1'b1;
                        x_reg   <= '0;
                        y_reg   <= '0;
                        z_reg   <= '0;
                        state_reg <= it_reg.last ? S_FIN : S_IDLE;
                    end
                    S_FIN: begin
                        if (cnt_reg == '0) begin
                            res_reg   <= '{bin: 10'd0, none: 1'b1};
                            emit_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else begin
                            q_reg     <= sum_reg;
                            drem_reg  <= '0;
                            step_reg  <= '0;
                            state_reg <= S_DIV;
                        end
                    end
                    S_DIV: begin
                        if (step_reg == 6'(DivSteps)) begin
                            res_reg.bin  <= (|mean[17:10]) ? BinMax : mean[9:0];
                            res_reg.none <= 1'b0;
                            emit_reg     <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                        else begin
                            q_reg    <= {q_reg[SumW-2:0], dv_ge};
                            drem_reg <= dv_ge ? drem_w - {1'b0, cnt_reg} : drem_w;
                            step_reg <= step_reg + 6'd1;
                        end
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

endmodule

[rtl/core/normal_angle_curvature_estimate.sv]
// ----------------------------------------------------------------------------
// normal_angle_curvature_estimate
// Mean angle between a query normal and its neighbor normals, per query.
// ----------------------------------------------------------------------------
// Words enter through a 4-deep input queue and are processed one at a time
// by a single sequencer: cross/dot products on one 16x16 multiplier,
// squares, integer sqrt (one root bit per cycle), CORDIC and accumulation;
// a skipped word that is not last is simply dequeued. A word marked last
// adds restoring division for the mean; the result then lands in a 2-deep
// output queue. angle_scale must be written only while idle; the block
// itself does not enforce it.
module normal_angle_curvature_estimate (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] query_x,
    input  logic signed [15:0] query_y,
    input  logic signed [15:0] query_z,
    input  logic signed [15:0] neighbor_x,
    input  logic signed [15:0] neighbor_y,
    input  logic signed [15:0] neighbor_z,
    input  logic               neighbor_valid,
    input  logic               last,
    output logic               empty,
    input  logic               pop,
    output logic [9:0]         curvature_bin,
    output logic               no_valid_neighbors,
    input  logic               angle_scale_we,
    input  logic [15:0]        angle_scale
);
    import nace_pkg::*;

    logic [15:0]  scale_reg;
    item_t        in_item;
    item_t        q_item;
    logic         q_valid;
    logic         deq;
    logic         res_full;
    logic         res_wr;
    result_t      res_data;
    result_t      rd_data;
    back_status_t status;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) scale_reg <= 16'd256;
        else if (angle_scale_we) scale_reg <= angle_scale;
    end

    assign in_item = '{qx: query_x, qy: query_y, qz: query_z,
                       nx: neighbor_x, ny: neighbor_y, nz: neighbor_z,
                       use_nb: neighbor_valid, last: last};

    nace_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .deq     (deq),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    nace_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .scale    (scale_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .deq      (deq),
        .res_full (res_full),
        .res_wr   (res_wr),
        .res_data (res_data),
        .status   (status)
    );

    nace_result u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (res_wr),
        .wr_data  (res_data),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .rd_data  (rd_data)
    );

    assign curvature_bin      = rd_data.bin;
    assign no_valid_neighbors = rd_data.none;

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid_count <= CntW'(MaxNeighbors))
        else $error("neighbor count above limit");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && no_valid_neighbors) |-> (curvature_bin == 10'd0))
        else $error("empty result with nonzero bin");

    a_pull_idle: assert property (@(posedge clk) disable iff (!rst_n)
        deq |=> status.busy || !$past(q_item.last && !q_item.use_nb))
        else $error("last word taken without starting result");

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the normal-angle curvature estimator against an in-bench predictor:
// directed corner words, scale register sweeps and random query groups with
// random gaps on both the push and the pop side.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nace_pkg::*;

    localparam int CycleLimit = 2000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [15:0] query_x = '0, query_y = '0, query_z = '0;
    logic signed [15:0] neighbor_x = '0, neighbor_y = '0, neighbor_z = '0;
    logic               neighbor_valid = 1'b0;
    logic               last = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [9:0]         curvature_bin;
    logic               no_valid_neighbors;
    logic               angle_scale_we = 1'b0;
    logic [15:0]        angle_scale = 16'd256;

    normal_angle_curvature_estimate dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .query_x            (query_x),
        .query_y            (query_y),
        .query_z            (query_z),
        .neighbor_x         (neighbor_x),
        .neighbor_y         (neighbor_y),
        .neighbor_z         (neighbor_z),
        .neighbor_valid     (neighbor_valid),
        .last               (last),
        .empty              (empty),
        .pop                (pop),
        .curvature_bin      (curvature_bin),
        .no_valid_neighbors (no_valid_neighbors),
        .angle_scale_we     (angle_scale_we),
        .angle_scale        (angle_scale)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [15:0]    scale_q;
    logic [39:0]    angle_sum;
    int             nb_count;
    result_t        bin_q[$];
    bit             failed = 1'b0;
    longint         cycles = 0;
    bit             gaps_on = 1'b1;

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint vec_angle(longint m, longint d);
        longint x, y, z, xs, ys;
        if (m == 0)
            return (d < 0) ? longint'(AngPi) : 0;
        if (d < 0)
        begin
            x = m; y = -d; z = AngHalfPi;
        end
        else
        begin
            x = d; y = m; z = 0;
        end
        for (int i = 0; i < CordicSteps; i++)
        begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z += atan_entry(i[3:0]);
            end
            else
            begin
                x = x - ys; y = y + xs; z -= atan_entry(i[3:0]);
            end
        end
        if (z < 0) z = 0;
        if (z > AngPi) z = AngPi;
        return z;
    endfunction

    function automatic void predict_curvature(item_t it);
        longint ax, ay, az, bx, by, bz, cx, cy, cz, d, m;
        longint unsigned sq, mean;
        result_t r;
        if (it.use_nb && nb_count < MaxNeighbors)
        begin
            ax = it.qx; ay = it.qy; az = it.qz;
            bx = it.nx; by = it.ny; bz = it.nz;
            cx = floor_shr(ay * bz - az * by, 2);
            cy = floor_shr(az * bx - ax * bz, 2);
            cz = floor_shr(ax * by - ay * bx, 2);
            d  = floor_shr(ax * bx + ay * by + az * bz, 2);
            sq = cx * cx + cy * cy + cz * cz;
            m  = int_sqrt(sq);
            angle_sum = angle_sum + 40'(vec_angle(m, d) * longint'(scale_q));
            nb_count++;
        end
        if (!it.last)
            return;
        if (nb_count == 0)
        begin
            r.bin = '0; r.none = 1'b1;
        end
        else
        begin
            mean = (64'(angle_sum) / nb_count) >> 22;
            r.bin = (mean > BinMax) ? BinMax : mean[9:0];
            r.none = 1'b0;
        end
        bin_q.push_back(r);
        angle_sum = '0;
        nb_count = 0;
    endfunction

    // push stays high into the next word when no gap is drawn
    task automatic send_word(item_t it);
        int gap;
        gap = gaps_on ? $urandom_range(15) : 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        query_x <= it.qx; query_y <= it.qy; query_z <= it.qz;
        neighbor_x <= it.nx; neighbor_y <= it.ny; neighbor_z <= it.nz;
        neighbor_valid <= it.use_nb;
        last <= it.last;
        push <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_curvature(it);
        @(negedge clk);
    endtask

    // pop side: random stall per word, check at the accepting edge
    initial
    begin
        int stall;
        result_t exp_r;
        forever
        begin
            stall = gaps_on ? $urandom_range(15) : 0;
            @(negedge clk);
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            if (bin_q.size() == 0)
            begin
                $display("%0t: unexpected word bin=%0d none=%0b", $time,
                         curvature_bin, no_valid_neighbors);
                failed = 1'b1;
            end
            else
            begin
                exp_r = bin_q.pop_front();
                if (curvature_bin !== exp_r.bin)
                begin
                    $display("%0t: curvature_bin expected %0d actual %0d", $time,
                             exp_r.bin, curvature_bin);
                    failed = 1'b1;
                end
                if (no_valid_neighbors !== exp_r.none)
                begin
                    $display("%0t: no_valid_neighbors expected %0b actual %0b",
                             $time, exp_r.none, no_valid_neighbors);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic drain();
        push <= 1'b0;
        while (bin_q.size() != 0) @(negedge clk);
        // skipped words may still sit in the input queue
        repeat (200) @(negedge clk);
    endtask

    task automatic set_scale(logic [15:0] v);
        drain();
        angle_scale <= v;
        angle_scale_we <= 1'b1;
        @(negedge clk);
        angle_scale_we <= 1'b0;
        scale_q = v;
    endtask

    function automatic item_t make_word(int qx, int qy, int qz, int nx, int ny,
                                        int nz, bit v, bit l);
        item_t it;
        it.qx = 16'(qx); it.qy = 16'(qy); it.qz = 16'(qz);
        it.nx = 16'(nx); it.ny = 16'(ny); it.nz = 16'(nz);
        it.use_nb = v; it.last = l;
        return it;
    endfunction

    function automatic item_t rand_word(bit l);
        item_t it;
        it = make_word($urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom_range(7) != 0, l);
        // sometimes near-parallel or anti-parallel normals
        if ($urandom_range(4) == 0)
        begin
            it.nx = $urandom_range(1) ? it.qx + $signed(5'($urandom)) : -it.qx;
            it.ny = it.qy;
            it.nz = it.qz;
        end
        return it;
    endfunction

    task automatic test_corners();
        send_word(make_word(32767, 0, 0, 32767, 0, 0, 1, 1));          // zero angle
        send_word(make_word(32767, 0, 0, -32768, 0, 0, 1, 1));         // anti-parallel
        send_word(make_word(32767, 0, 0, 0, 32767, 0, 1, 1));          // right angle
        send_word(make_word(-32768, -32768, -32768, 32767, -32768, 32767, 1, 1));
        send_word(make_word(20000, 5000, 0, -30000, 1000, 7, 1, 1));   // negative dot
        send_word(make_word(0, 0, 0, 1234, -4321, 99, 1, 1));          // zero-length
        send_word(make_word(-1, -1, -1, -1, -1, -1, 0, 1));            // no valid
        send_word(make_word(100, 200, 300, 400, 500, 600, 1, 0));
        send_word(make_word(0, 0, 0, 0, 0, 0, 0, 1));                  // invalid last
        for (int i = 0; i < 24; i++)                                   // overflow count
            send_word(make_word(32767, 0, 0, -32768, 1, 0, 1, i == 23));
    endtask

    task automatic test_random_groups(int n_words);
        int sent, len;
        sent = 0;
        while (sent < n_words)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(22, 26) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                send_word(rand_word(k == len - 1));
            sent += len;
        end
    endtask

    task automatic test_scale_sweep();
        set_scale(16'hFFFF);
        test_random_groups(60);
        send_word(make_word(32767, 0, 0, -32768, 0, 0, 1, 1));  // largest angle at full scale
        set_scale(16'h0000);
        test_random_groups(30);
        set_scale(16'h0001);
        test_random_groups(30);
        set_scale($urandom);
        test_random_groups(80);
        set_scale(16'd256);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        test_random_groups(60);
        drain();  // sender holds off until all results are in
        gaps_on = 1'b1;
        test_random_groups(120);
    endtask

    initial
    begin
        scale_q = 16'd256;
        angle_sum = '0;
        nb_count = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_corners();
        test_scale_sweep();
        test_back_to_back();
        drain();
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
